>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the stack RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/lss_pkg.sv
// ---------------------------------------------------------------------------
// lss_pkg
// Types and codes of the LIFO stack with sort.
// ---------------------------------------------------------------------------
package lss_pkg;

  // Command codes
  localparam logic [2:0] CMD_PUSH        = 3'd0;
  localparam logic [2:0] CMD_POP         = 3'd1;
  localparam logic [2:0] CMD_PEEK        = 3'd2;
  localparam logic [2:0] CMD_PUSH_BOTTOM = 3'd3;
  localparam logic [2:0] CMD_SORT        = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam int WORD_W = 32;
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  // Command word
  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [WORD_W-1:0] value;
  } lss_in_t;

  // Result word
  typedef struct packed {
    logic signed [WORD_W-1:0] data_out;
    logic [1:0]               status;
    logic                     is_empty;
    logic                     is_full;
    logic [7:0]               fill_count;
  } lss_out_t;

  // Completion from the sequencer
  typedef struct packed {
    logic                     valid;
    logic signed [WORD_W-1:0] data;
    logic [1:0]               status;
  } lss_done_t;

endpackage

>>> rtl/lss_ram.sv
// ---------------------------------------------------------------------------
// lss_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/lss_seq.sv
// ---------------------------------------------------------------------------
// lss_seq
// Command sequencer: keeps the occupancy, drives the entry RAM for
// push/pop/peek, the bottom-insert shift walk and the in-place insertion sort.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lss_seq
  import lss_pkg::*;
#(
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lss_in_t           in_word,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [WORD_W-1:0] ram_wdata,
  output logic [AW-1:0]     ram_raddr,
  input  logic [WORD_W-1:0] ram_rdata,
  output lss_done_t         done,
  output logic [CW-1:0]     occ_next
);

  typedef enum logic [2:0] {
    S_IDLE, S_RDTOP, S_PBSH, S_PBFIN, S_KEY, S_CMP, S_PLACE
  } state_t;

  state_t                   state_r, state_nxt;
  logic [2:0]               cmd_r, cmd_nxt;
  logic signed [WORD_W-1:0] value_r, value_nxt;
  logic signed [WORD_W-1:0] key_r, key_nxt;
  logic [CW-1:0]            occ_r, occ_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic [AW-1:0]            j_r, j_nxt;

  logic                     full, empty;
  logic [AW-1:0]            top_addr;
  logic [CW-1:0]            idx_plus;
  logic signed [WORD_W-1:0] rd_s;

  assign full     = (occ_r == CW'(DEPTH));
  assign empty    = (occ_r == '0);
  assign top_addr = AW'(occ_r - CW'(1));
  assign idx_plus = CW'(idx_r) + CW'(1);
  assign rd_s     = $signed(ram_rdata);
  assign busy     = (state_r != S_IDLE);
  assign occ_next = occ_nxt;

  // next state, RAM control and completion
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    value_nxt = value_r;
    key_nxt   = key_r;
    occ_nxt   = occ_r;
    idx_nxt   = idx_r;
    j_nxt     = j_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    done      = '{valid: 1'b0, data: '0, status: ST_OK};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_word.cmd;
          value_nxt = in_word.value;
          unique case (in_word.cmd)
            CMD_PUSH: begin
              done.valid = 1'b1;
              if (full) begin
                done.status = ST_OVERFLOW;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(occ_r);
                ram_wdata = in_word.value;
                occ_nxt   = occ_r + CW'(1);
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (empty) begin
                done.valid  = 1'b1;
                done.data   = EMPTY_WORD;
                done.status = (in_word.cmd == CMD_POP) ? ST_UNDERFLOW : ST_EMPTY;
              end else begin
                ram_raddr = top_addr;
                state_nxt = S_RDTOP;
              end
            end
            CMD_PUSH_BOTTOM: begin
              if (full) begin
                done.valid  = 1'b1;
                done.status = ST_OVERFLOW;
              end else if (empty) begin
                done.valid = 1'b1;
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = in_word.value;
                occ_nxt    = occ_r + CW'(1);
              end else begin
                ram_raddr = top_addr;
                idx_nxt   = top_addr;
                state_nxt = S_PBSH;
              end
            end
            CMD_SORT: begin
              if (occ_r < CW'(2)) begin
                done.valid = 1'b1;
              end else begin
                ram_raddr = AW'(1);
                idx_nxt   = AW'(1);
                state_nxt = S_KEY;
              end
            end
            default: begin
              done.valid = 1'b1;
            end
          endcase
        end
      end

      // top word arrives from the RAM
      S_RDTOP: begin
        done.valid = 1'b1;
        done.data  = rd_s;
        if (cmd_r == CMD_POP) begin
          occ_nxt = occ_r - CW'(1);
        end
        state_nxt = S_IDLE;
      end

      // shift walk: move entry idx up one place, fetch the one below
      S_PBSH: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r + AW'(1);
        ram_wdata = ram_rdata;
        if (idx_r == '0) begin
          state_nxt = S_PBFIN;
        end else begin
          ram_raddr = idx_r - AW'(1);
          idx_nxt   = idx_r - AW'(1);
        end
      end

      // new word lands at the bottom
      S_PBFIN: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = value_r;
        occ_nxt    = occ_r + CW'(1);
        done.valid = 1'b1;
        state_nxt  = S_IDLE;
      end

      // sort: latch key, fetch its lower neighbor
      S_KEY: begin
        key_nxt   = rd_s;
        j_nxt     = idx_r;
        ram_raddr = idx_r - AW'(1);
        state_nxt = S_CMP;
      end

      // sort: neighbor smaller than key moves up, else key settles at j
      S_CMP: begin
        ram_we = 1'b1;
        if (rd_s < key_r) begin
          ram_waddr = j_r;
          ram_wdata = ram_rdata;
          j_nxt     = j_r - AW'(1);
          if (j_r == AW'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            ram_raddr = j_r - AW'(2);
          end
        end else begin
          ram_waddr = j_r;
          ram_wdata = key_r;
          if (idx_plus < occ_r) begin
            ram_raddr = AW'(idx_plus);
            idx_nxt   = AW'(idx_plus);
            state_nxt = S_KEY;
          end else begin
            done.valid = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end

      // sort: key goes to the bottom
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = key_r;
        if (idx_plus < occ_r) begin
          ram_raddr = AW'(idx_plus);
          idx_nxt   = AW'(idx_plus);
          state_nxt = S_KEY;
        end else begin
          done.valid = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
    end
    cmd_r   <= cmd_nxt;
    value_r <= value_nxt;
    key_r   <= key_nxt;
    idx_r   <= idx_nxt;
    j_r     <= j_nxt;
  end

  // checks
  `ASSERT_CLK(a_occ_bound, occ_r <= CW'(DEPTH), "occupancy above DEPTH")
  `ASSERT_CLK(a_wr_in_range, ram_we |-> (CW'(ram_waddr) <= occ_r), "write beyond top of stack")
  `ASSERT_CLK(a_rdtop_nonempty, (state_r == S_RDTOP) |-> !empty, "top read on empty stack")
  `ASSERT_CLK(a_done_to_idle, (done.valid && busy) |=> (state_r == S_IDLE), "walk did not end")

endmodule

>>> rtl/lifo_stack_with_sort.sv
// ---------------------------------------------------------------------------
// lifo_stack_with_sort
// Bounded LIFO stack of signed 32-bit words with push-bottom and sort.
// ---------------------------------------------------------------------------
// Channel   Ports                       Handshake
// command   start, busy, in_word        taken when start & !busy
// result    out_valid, out_word         one word per command, one-cycle strobe
//
// Completed in the idle state: push, unknown commands, overflow, pop/peek
// on an empty stack, push-bottom onto an empty stack and sort of fewer
// than two entries. Pop and peek otherwise: the top word comes back from
// the registered RAM read in S_RDTOP. Push-bottom otherwise: shift walk in
// S_PBSH, one entry moved per cycle, then the new word lands in S_PBFIN.
// Sort: insertion sort in the RAM (S_KEY, S_CMP, S_PLACE); busy stays high throughout.
// The result strobe is registered and rises in the cycle after the last cycle of a command.
// Synchronous reset empties the stack; no RAM clearing pass is needed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lifo_stack_with_sort
  import lss_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  lss_in_t  in_word,
  output logic     out_valid,
  output lss_out_t out_word
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  lss_done_t         done;
  logic [CW-1:0]     occ_next;
  logic              out_valid_r;
  lss_out_t          out_word_r;

  lss_seq #(.DEPTH(DEPTH)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .done      (done),
    .occ_next  (occ_next)
  );

  lss_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= done.valid;
    end
  end

  // result word with fill flags
  always_ff @(posedge clk) begin
    out_word_r.data_out   <= done.data;
    out_word_r.status     <= done.status;
    out_word_r.is_empty   <= (occ_next == '0);
    out_word_r.is_full    <= (occ_next == CW'(DEPTH));
    out_word_r.fill_count <= 8'(occ_next);
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `ASSERT_CLK(a_out_has_cause, out_valid |-> $past(start || busy), "result word without command")

endmodule

>>> verif/tb_lifo_stack_with_sort.sv
// ---------------------------------------------------------------------------
// tb_lifo_stack_with_sort
// Drives push, pop, peek, push-bottom, sort and unused commands into the
// stack, keeps a shadow copy of the stack contents and occupancy, and
// checks every result word field by field against the shadow prediction.
// ---------------------------------------------------------------------------
module tb_lifo_stack_with_sort
  import lss_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 128;
  localparam int IN_W  = $bits(lss_in_t);

  // Command codes with no defined operation
  localparam logic [2:0] CMD_RSVD_LO  = 3'd5;
  localparam logic [2:0] CMD_RSVD_MID = 3'd6;
  localparam logic [2:0] CMD_RSVD_HI  = 3'd7;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  lss_in_t  in_word;
  logic     out_valid;
  lss_out_t out_word;

  // Shadow stack: entry 0 is the bottom
  logic signed [WORD_W-1:0] shadow_entries [DEPTH];
  int                       shadow_count = 0;

  lss_out_t stack_replies_due [$];
  int       mismatch_count = 0;
  int       gap_pct = 0;

  lifo_stack_with_sort #(.DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  // Apply one command to the shadow stack and return the result it gives
  function automatic lss_out_t stack_cmd_outcome(lss_in_t w);
    lss_out_t                 r;
    logic signed [WORD_W-1:0] key;
    int                       j;
    r = '0;
    case (w.cmd)
      CMD_PUSH: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          shadow_entries[shadow_count] = w.value;
          shadow_count++;
        end
      end
      CMD_POP: begin
        if (shadow_count == 0) begin
          r.status   = ST_UNDERFLOW;
          r.data_out = EMPTY_WORD;
        end else begin
          shadow_count--;
          r.data_out = shadow_entries[shadow_count];
        end
      end
      CMD_PEEK: begin
        if (shadow_count == 0) begin
          r.status   = ST_EMPTY;
          r.data_out = EMPTY_WORD;
        end else begin
          r.data_out = shadow_entries[shadow_count-1];
        end
      end
      CMD_PUSH_BOTTOM: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          for (int k = shadow_count; k > 0; k--) shadow_entries[k] = shadow_entries[k-1];
          shadow_entries[0] = w.value;
          shadow_count++;
        end
      end
      CMD_SORT: begin
        // largest at the bottom, smallest on top
        for (int i = 1; i < shadow_count; i++) begin
          key = shadow_entries[i];
          j   = i;
          while (j > 0 && shadow_entries[j-1] < key) begin
            shadow_entries[j] = shadow_entries[j-1];
            j--;
          end
          shadow_entries[j] = key;
        end
      end
      default: ;
    endcase
    r.is_empty   = (shadow_count == 0);
    r.is_full    = (shadow_count == DEPTH);
    r.fill_count = 8'(shadow_count);
    return r;
  endfunction

  function automatic lss_in_t stack_cmd(logic [2:0] cmd, logic signed [WORD_W-1:0] value);
    lss_in_t w;
    w.cmd   = cmd;
    w.value = value;
    return w;
  endfunction

  // Extremes, small values (for duplicates) and full-range words
  function automatic logic signed [WORD_W-1:0] stack_word_pick();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return EMPTY_WORD;
      4, 5:    return $signed(32'($urandom_range(15))) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Send one word, wait for it to be taken, then maybe leave a gap
  task automatic issue_word(lss_in_t w);
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    stack_replies_due.push_back(stack_cmd_outcome(w));
    while ($urandom_range(99) < gap_pct) begin
      start   <= 1'b0;
      in_word <= IN_W'({$urandom, $urandom});
      @(posedge clk);
    end
  endtask

  task automatic test_empty_stack();
    issue_word(stack_cmd(CMD_PEEK, 32'sd9));
    issue_word(stack_cmd(CMD_POP, 32'sd9));
    issue_word(stack_cmd(CMD_SORT, '0));
    issue_word(stack_cmd(CMD_RSVD_LO, 32'h1234_5678));
    issue_word(stack_cmd(CMD_RSVD_MID, 32'h7FFF_FFFF));
    issue_word(stack_cmd(CMD_RSVD_HI, 32'h8000_0000));
  endtask

  task automatic test_basic_ops();
    issue_word(stack_cmd(CMD_PUSH_BOTTOM, 32'sd5));
    issue_word(stack_cmd(CMD_POP, '0));
    issue_word(stack_cmd(CMD_PUSH, 32'h7FFF_FFFF));
    issue_word(stack_cmd(CMD_SORT, '0));             // single entry
    issue_word(stack_cmd(CMD_PUSH, 32'h8000_0000));
    issue_word(stack_cmd(CMD_PUSH, '0));
    issue_word(stack_cmd(CMD_PUSH_BOTTOM, EMPTY_WORD));
    issue_word(stack_cmd(CMD_PUSH, '0));             // equal words
    issue_word(stack_cmd(CMD_PEEK, '0));
    issue_word(stack_cmd(CMD_SORT, '0));
    issue_word(stack_cmd(CMD_PEEK, '0));
    repeat (5) issue_word(stack_cmd(CMD_POP, '0));
    issue_word(stack_cmd(CMD_POP, '0));              // underflow
    issue_word(stack_cmd(CMD_PEEK, '0));             // empty
  endtask

  // Fill to the top, hit overflow both ways, sort full, drain past empty
  task automatic test_full_stack();
    while (shadow_count < DEPTH)
      issue_word(stack_cmd($urandom_range(3) == 0 ? CMD_PUSH_BOTTOM : CMD_PUSH,
                           stack_word_pick()));
    issue_word(stack_cmd(CMD_PUSH, 32'sd1));
    issue_word(stack_cmd(CMD_PUSH_BOTTOM, 32'sd2));
    issue_word(stack_cmd(CMD_RSVD_HI, '0));
    issue_word(stack_cmd(CMD_PEEK, '0));
    issue_word(stack_cmd(CMD_SORT, '0));
    while (shadow_count > 0) issue_word(stack_cmd(CMD_POP, '0));
    issue_word(stack_cmd(CMD_POP, '0));
  endtask

  // Random commands; each run of 150 leans at random toward growing or shrinking the stack
  task automatic test_random_mix(int count);
    bit         climbing;
    int         roll;
    logic [2:0] cmd;
    climbing = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) climbing = ($urandom_range(99) < 55);
      roll = $urandom_range(99);
      if (roll >= 96)            cmd = 3'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
      else if (roll >= 94)       cmd = CMD_SORT;
      else if (roll >= 80)       cmd = CMD_PEEK;
      else if (climbing) begin
        if (roll < 50)           cmd = CMD_PUSH;
        else if (roll < 62)      cmd = CMD_PUSH_BOTTOM;
        else                     cmd = CMD_POP;
      end else begin
        if (roll < 20)           cmd = CMD_PUSH;
        else if (roll < 26)      cmd = CMD_PUSH_BOTTOM;
        else                     cmd = CMD_POP;
      end
      issue_word(stack_cmd(cmd, stack_word_pick()));
    end
  endtask

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Result checker: every strobed word pairs with the oldest prediction
  always @(posedge clk) begin
    lss_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (stack_replies_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result word, expected none actual %0h", $time, out_word);
      end else begin
        want = stack_replies_due.pop_front();
        report_field("data_out", want.data_out, out_word.data_out);
        report_field("status", 32'(want.status), 32'(out_word.status));
        report_field("is_empty", 32'(want.is_empty), 32'(out_word.is_empty));
        report_field("is_full", 32'(want.is_full), 32'(out_word.is_full));
        report_field("fill_count", 32'(want.fill_count), 32'(out_word.fill_count));
      end
    end
  end

  // Run limit
  initial begin
    #1_000_000_000;
    $display("tb_lifo_stack_with_sort: errors");
    $finish;
  end

  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_word <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct = 7;
    test_empty_stack();
    test_basic_ops();
    test_full_stack();
    test_random_mix(570);
    gap_pct = 58;
    test_random_mix(570);
    gap_pct = 0;
    test_random_mix(570);
    start <= 1'b0;

    // drain outstanding results
    while (stack_replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_lifo_stack_with_sort: clean");
    end else begin
      $display("tb_lifo_stack_with_sort: errors");
    end
    $finish;
  end

endmodule
